// ===== rtl/tdo_pkg.sv =====
// Shared widths, side-band types and the output saturation helper.
`default_nettype none
package tdo_pkg;

    localparam int CW      = 32;            // coordinate and weight width
    localparam int FB      = 16;            // fraction bits
    localparam int NV      = 9;             // coordinates per triangle
    localparam int NW_OUT  = 6;             // weights per result
    localparam int EW      = CW + 1;        // edge width, signed
    localparam int PRW     = 2 * EW;        // edge by edge product, signed
    localparam int PW      = PRW + 1;       // |e1|^2, signed container
    localparam int QW      = PRW + 2;       // e1.e2, signed
    localparam int XW      = PRW + 1;       // cross component, signed
    localparam int XMW     = PRW;           // cross component magnitude
    localparam int HW      = XMW / 2;       // half of a cross magnitude
    localparam int C2W     = 2 * XMW + 2;   // |e1 x e2|^2, also the root radicand
    localparam int RW      = C2W / 2;       // root width, one stage per root bit
    localparam int LW      = PW / 2 + 1;    // edge length width
    localparam int CH      = (RW + 2) / 3;  // area root chunk for the den multiply
    localparam int PPW     = LW + 3 * CH;   // den sum width before truncation
    localparam int DW      = LW + RW;       // denominator width
    localparam int NW      = QW;            // numerator magnitude width
    localparam int QB      = CW + 1;        // quotient bits kept
    localparam int SH      = QB - 2 * FB;   // numerator bits below the first remainder
    localparam int DIV_LAT = QB + 2;        // prep + quotient stages + rounding
    localparam int GEO_LAT = 7;

    typedef struct packed {
        logic [NW-1:0] n10_mag;
        logic          n10_neg;
        logic [NW-1:0] n11_mag;
        logic          n11_neg;
        logic [NW-1:0] n12_mag;
    } t_num;

    typedef struct packed {
        logic deg;
        logic n10_neg;
        logic n11_neg;
    } t_wside;

    // Clamp a rounded quotient magnitude into a signed weight.
    function automatic logic [CW-1:0] sat_w(input logic [QB:0] q, input logic neg);
        logic [QB:0] neg_lim;
        logic [QB:0] pos_lim;
        logic [QB:0] mag;
        logic        neg_eff;
        neg_lim = (QB + 1)'(1) << (CW - 1);
        pos_lim = neg_lim - (QB + 1)'(1);
        neg_eff = neg && (q != '0);
        if (neg_eff) begin
            mag = (q > neg_lim) ? neg_lim : q;
            return -mag[CW-1:0];
        end else begin
            mag = (q > pos_lim) ? pos_lim : q;
            return mag[CW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/triangle_deformation_operator.sv =====
// Triangle deformation-gradient operator: 2x3 weights from three Q16.16 vertices.
//
// Input stream (s_axis): one word per triangle, nine 32-bit signed Q16.16
// coordinates v0..v2 (x, y, z each). Output stream (m_axis): one word per
// triangle, weights w00 w01 w02 w10 w11 w12 (signed Q16.16, saturated) in
// tdata, degenerate flag in tuser.
// Throughput: one triangle per cycle unless the receiver stalls. Input accept
// to output valid: geometry, root, denominator, divide and output stages.
// The root stages (one bit per stage for the 134-bit area radicand) and the
// 33 quotient stages of the dividers set the latency.
// A degenerate triangle (zero edge or zero area) gives all-zero weights
// and tuser = 1.
// Reset clears all valid bits; the output is empty after reset.
// When the receiver stalls with a word held in the output register, the
// whole pipeline freezes and s_axis tready falls in the same cycle; nothing
// is dropped or repeated. An empty output register keeps tready high.
`default_nettype none
module triangle_deformation_operator
    import tdo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  wire logic [NV*CW-1:0]      i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // w00, w01, w02, w10, w11, w12
    output logic [NW_OUT*CW-1:0]       o_m_axis_tdata,
    // degenerate
    output logic [0:0]                 o_m_axis_tuser
);

    logic ce;

    logic           geo_valid;
    logic [C2W-1:0] geo_c2;
    logic [PW-1:0]  geo_p;
    t_num           geo_num;

    logic           sq_valid;
    logic [RW-1:0]  sq_area;
    logic [RW-1:0]  sq_len;
    t_num           sq_num;

    logic [3*CH-1:0] a2x;

    logic             r_v1;
    logic [LW+CH-1:0] r_pp [3];
    logic [LW-1:0]    r_l1;
    t_num             r_num1;
    logic             r_deg1;

    logic             r_v2;
    logic [DW-1:0]    r_den2;
    logic [LW-1:0]    r_l2;
    t_num             r_num2;
    logic             r_deg2;

    logic [DIV_LAT-1:0] r_dv;
    t_wside             r_ds [DIV_LAT];

    logic [QB:0] q_inv;
    logic [QB:0] q_10;
    logic [QB:0] q_11;
    logic [QB:0] q_12;

    logic                   r_ov;
    logic [NW_OUT*CW-1:0]   r_od;
    logic                   r_odeg;

    assign ce              = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    tdo_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_valid (geo_valid),
        .o_c2    (geo_c2),
        .o_p     (geo_p),
        .o_num   (geo_num)
    );

    tdo_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (geo_valid),
        .i_rad_a  (geo_c2),
        .i_rad_b  (C2W'(geo_p)),
        .i_side   (geo_num),
        .o_valid  (sq_valid),
        .o_root_a (sq_area),
        .o_root_b (sq_len),
        .o_side   (sq_num)
    );

    assign a2x = (3 * CH)'(sq_area);

    // L * A2 in three partial products, then summed into the denominator register
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                r_pp[k] <= sq_len[LW-1:0] * a2x[k*CH +: CH];
            end
            r_l1   <= sq_len[LW-1:0];
            r_num1 <= sq_num;
            r_deg1 <= (sq_len == '0) || (sq_area == '0);

            r_den2 <= DW'(PPW'(r_pp[0]) + (PPW'(r_pp[1]) << CH) + (PPW'(r_pp[2]) << (2 * CH)));
            r_l2   <= r_l1;
            r_num2 <= r_num1;
            r_deg2 <= r_deg1;

            r_ds[0].deg     <= r_deg2;
            r_ds[0].n10_neg <= r_num2.n10_neg;
            r_ds[0].n11_neg <= r_num2.n11_neg;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_ds[k] <= r_ds[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (ce) begin
            r_v1 <= sq_valid;
            r_v2 <= r_v1;
            r_dv <= {r_dv[DIV_LAT-2:0], r_v2};
            r_ov <= r_dv[DIV_LAT-1];
        end
    end

    tdo_div u_div_inv (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (NW'(1)),
        .i_den (DW'(r_l2)),
        .o_q   (q_inv)
    );

    tdo_div u_div_10 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_num2.n10_mag),
        .i_den (r_den2),
        .o_q   (q_10)
    );

    tdo_div u_div_11 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_num2.n11_mag),
        .i_den (r_den2),
        .o_q   (q_11)
    );

    tdo_div u_div_12 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_num2.n12_mag),
        .i_den (r_den2),
        .o_q   (q_12)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_odeg <= r_ds[DIV_LAT-1].deg;
            if (r_ds[DIV_LAT-1].deg) begin
                r_od <= '0;
            end else begin
                r_od <= {sat_w(q_12, 1'b0),
                         sat_w(q_11, r_ds[DIV_LAT-1].n11_neg),
                         sat_w(q_10, r_ds[DIV_LAT-1].n10_neg),
                         CW'(0),
                         sat_w(q_inv, 1'b0),
                         sat_w(q_inv, 1'b1)};
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;
    assign o_m_axis_tuser  = r_odeg;

endmodule
`default_nettype wire

// ===== rtl/tdo_geom.sv =====
// Edge, dot product and cross product pipeline: |e1|^2, e1.e2, |e1 x e2|^2 and the weight numerators.
`default_nettype none
module tdo_geom
    import tdo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ce,
    input  wire logic              i_valid,
    input  wire logic [NV*CW-1:0]  i_data,
    output logic                   o_valid,
    output logic [C2W-1:0]         o_c2,
    output logic [PW-1:0]          o_p,
    output t_num                   o_num
);

    logic [GEO_LAT-1:0] r_v;

    logic signed [EW-1:0]  r_e1 [3];
    logic signed [EW-1:0]  r_e2 [3];
    logic signed [PRW-1:0] r_pe [3];
    logic signed [PRW-1:0] r_pq [3];
    logic signed [PRW-1:0] r_pa [3];
    logic signed [PRW-1:0] r_pb [3];
    logic signed [PW-1:0]  r_p3, r_p4, r_p5, r_p6, r_p7;
    logic signed [QW-1:0]  r_q3, r_q4, r_q5, r_q6;
    logic signed [XW-1:0]  r_cr [3];
    logic [XMW-1:0]        r_cm [3];
    logic [2*HW-1:0]       r_hh [3];
    logic [2*HW-1:0]       r_hl [3];
    logic [2*HW-1:0]       r_ll [3];
    logic [C2W-1:0]        r_sq [3];
    logic signed [QW:0]    r_n10;
    logic [C2W-1:0]        r_c2;
    t_num                  r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[GEO_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EW'($signed(i_data[(3 + k)*CW +: CW]))
                         - EW'($signed(i_data[k*CW +: CW]));
                r_e2[k] <= EW'($signed(i_data[(6 + k)*CW +: CW]))
                         - EW'($signed(i_data[k*CW +: CW]));
            end
            for (int k = 0; k < 3; k++) begin
                r_pe[k] <= r_e1[k] * r_e1[k];
                r_pq[k] <= r_e1[k] * r_e2[k];
                r_pa[k] <= r_e1[(k + 1) % 3] * r_e2[(k + 2) % 3];
                r_pb[k] <= r_e1[(k + 2) % 3] * r_e2[(k + 1) % 3];
            end
            r_p3 <= PW'(r_pe[0]) + PW'(r_pe[1]) + PW'(r_pe[2]);
            r_q3 <= QW'(r_pq[0]) + QW'(r_pq[1]) + QW'(r_pq[2]);
            for (int k = 0; k < 3; k++) begin
                r_cr[k] <= XW'(r_pa[k]) - XW'(r_pb[k]);
            end
            // magnitude of each cross component
            r_p4 <= r_p3;
            r_q4 <= r_q3;
            for (int k = 0; k < 3; k++) begin
                r_cm[k] <= r_cr[k][XW-1] ? XMW'(-r_cr[k]) : XMW'(r_cr[k]);
            end
            // square split into half-width partial products
            r_p5 <= r_p4;
            r_q5 <= r_q4;
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= r_cm[k][XMW-1:HW] * r_cm[k][XMW-1:HW];
                r_hl[k] <= r_cm[k][XMW-1:HW] * r_cm[k][HW-1:0];
                r_ll[k] <= r_cm[k][HW-1:0]   * r_cm[k][HW-1:0];
            end
            r_p6  <= r_p5;
            r_q6  <= r_q5;
            r_n10 <= (QW + 1)'(r_q5) - (QW + 1)'(r_p5);
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (C2W'(r_hh[k]) << (2 * HW)) + (C2W'(r_hl[k]) << (HW + 1))
                         + C2W'(r_ll[k]);
            end
            r_p7 <= r_p6;
            r_c2 <= r_sq[0] + r_sq[1] + r_sq[2];
            r_num.n10_mag <= r_n10[QW] ? NW'(-r_n10) : NW'(r_n10);
            r_num.n10_neg <= r_n10[QW];
            r_num.n11_mag <= r_q6[QW-1] ? NW'(-r_q6) : NW'(r_q6);
            r_num.n11_neg <= !r_q6[QW-1] && (r_q6 != '0);
            r_num.n12_mag <= NW'(r_p6);
        end
    end

    assign o_valid = r_v[GEO_LAT-1];
    assign o_c2    = r_c2;
    assign o_p     = r_p7;
    assign o_num   = r_num;

endmodule
`default_nettype wire

// ===== rtl/tdo_sqrt.sv =====
// Two-lane floor square root, one root bit per pipeline stage.
`default_nettype none
module tdo_sqrt
    import tdo_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_ce,
    input  wire logic           i_valid,
    input  wire logic [C2W-1:0] i_rad_a,
    input  wire logic [C2W-1:0] i_rad_b,
    input  wire t_num           i_side,
    output logic                o_valid,
    output logic [RW-1:0]       o_root_a,
    output logic [RW-1:0]       o_root_b,
    output t_num                o_side
);

    logic [RW+1:0]  r_rem  [RW][2];
    logic [RW-1:0]  r_root [RW][2];
    logic [C2W-1:0] r_rad  [RW][2];
    t_num           r_side [RW];
    logic [RW-1:0]  r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic [RW+1:0]  p_rem  [2];
        logic [RW-1:0]  p_root [2];
        logic [C2W-1:0] p_rad  [2];
        logic [RW+1:0]  n_rem  [2];
        logic [RW-1:0]  n_root [2];
        t_num           p_side;

        if (s == 0) begin : g_first
            always_comb begin
                p_rem[0]  = '0;
                p_rem[1]  = '0;
                p_root[0] = '0;
                p_root[1] = '0;
                p_rad[0]  = i_rad_a;
                p_rad[1]  = i_rad_b;
                p_side    = i_side;
            end
        end else begin : g_next
            always_comb begin
                p_rem[0]  = r_rem[s-1][0];
                p_rem[1]  = r_rem[s-1][1];
                p_root[0] = r_root[s-1][0];
                p_root[1] = r_root[s-1][1];
                p_rad[0]  = r_rad[s-1][0];
                p_rad[1]  = r_rad[s-1][1];
                p_side    = r_side[s-1];
            end
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                logic [RW+1:0] rem2;
                logic [RW+1:0] trial;
                rem2  = {p_rem[l][RW-1:0], p_rad[l][C2W-1 -: 2]};
                trial = {p_root[l], 2'b01};
                if (rem2 >= trial) begin
                    n_rem[l]  = rem2 - trial;
                    n_root[l] = {p_root[l][RW-2:0], 1'b1};
                end else begin
                    n_rem[l]  = rem2;
                    n_root[l] = {p_root[l][RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l]  <= n_rem[l];
                    r_root[s][l] <= n_root[l];
                    r_rad[s][l]  <= p_rad[l] << 2;
                end
                r_side[s] <= p_side;
            end
        end
    end

    assign o_valid  = r_v[RW-1];
    assign o_root_a = r_root[RW-1][0];
    assign o_root_b = r_root[RW-1][1];
    assign o_side   = r_side[RW-1];

endmodule
`default_nettype wire

// ===== rtl/tdo_div.sv =====
// Pipelined restoring divider: rounded (num * 2^2F) / den, one quotient bit per stage.
`default_nettype none
module tdo_div
    import tdo_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_ce,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic [QB:0]        o_q
);

    logic [DW:0]   r_r   [QB+1];
    logic [DW-1:0] r_d   [QB+1];
    logic [QB-1:0] r_lo  [QB+1];
    logic [QB-1:0] r_qq  [QB+1];
    logic          r_ovf [QB+1];
    logic [QB:0]   r_q;

    // quotient would need more than QB bits: saturates downstream anyway
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf[0] <= (DW + 1 + SH)'(i_num) >= {i_den, {(SH + 1){1'b0}}} >> 1;
            r_r[0]   <= (DW + 1)'(i_num >> SH);
            r_lo[0]  <= {i_num[SH-1:0], {(2 * FB){1'b0}}};
            r_d[0]   <= i_den;
            r_qq[0]  <= '0;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        logic [DW:0] n_rs;
        logic        n_ge;

        always_comb begin
            n_rs = {r_r[s-1][DW-1:0], r_lo[s-1][QB-1]};
            n_ge = n_rs >= {1'b0, r_d[s-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_r[s]   <= n_ge ? n_rs - {1'b0, r_d[s-1]} : n_rs;
                r_qq[s]  <= {r_qq[s-1][QB-2:0], n_ge};
                r_lo[s]  <= r_lo[s-1] << 1;
                r_d[s]   <= r_d[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (r_ovf[QB]) begin
                r_q <= '1;
            end else begin
                r_q <= (QB + 1)'(r_qq[QB])
                     + (QB + 1)'({r_r[QB], 1'b0} >= (DW + 2)'(r_d[QB]));
            end
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// ===== dv/tb_triangle_deformation_operator.sv =====
// Self-checking testbench for the triangle deformation-gradient operator.
`timescale 1ns / 100ps
module tb_triangle_deformation_operator;
    import tdo_pkg::*;

    localparam int N_RAND    = 1950;
    localparam int LIMIT     = 600000;
    localparam int TAIL_FREE = 200;
    localparam int HOLD_LEN  = 400;

    typedef logic [255:0] u256_t;
    typedef logic signed [255:0] s256_t;

    typedef struct packed {
        logic [NW_OUT-1:0][CW-1:0] w;
        logic                      deg;
    } t_weights;

    typedef struct {
        logic [NV-1:0][CW-1:0] v;
        bit                    typed;
        t_weights              wt;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [NV*CW-1:0]      i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [NW_OUT*CW-1:0]  o_m_axis_tdata;
    logic [0:0]            o_m_axis_tuser;

    t_weights weights_due[$];
    int       n_errors;
    int       n_sent;
    int       n_deg;
    int       n_checked;
    int       cycles;
    bit       calm;
    bit       hold_req;

    triangle_deformation_operator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic u256_t floor_root(input u256_t a);
        u256_t res, rem, bitv, t;
        res = '0;
        rem = a;
        for (int k = 254; k >= 0; k -= 2) begin
            bitv = u256_t'(1) << k;
            t = res + bitv;
            if (rem >= t) begin
                rem = rem - t;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // round to nearest, ties away from zero, on magnitudes
    function automatic u256_t div_round(input u256_t n, input u256_t d);
        u256_t q, r;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 1;
        return q;
    endfunction

    function automatic logic [CW-1:0] clamp_weight(input u256_t q, input bit neg);
        u256_t lim;
        lim = (u256_t'(1) << (CW - 1)) - (neg ? 0 : 1);
        if (q > lim) q = lim;
        return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] scaled_weight(input s256_t num, input u256_t den);
        u256_t mag, q;
        mag = (num < 0) ? u256_t'(-num) : u256_t'(num);
        q = div_round(mag << (2 * FB), den);
        return clamp_weight(q, (num < 0) && (q != 0));
    endfunction

    function automatic t_weights triangle_weights(input logic [NV-1:0][CW-1:0] v);
        s256_t e1[3], e2[3], cr, q;
        u256_t p, c2, len, area, den, inv;
        t_weights r;
        p = '0;
        c2 = '0;
        q = '0;
        for (int k = 0; k < 3; k++) begin
            e1[k] = s256_t'($signed(v[3 + k])) - s256_t'($signed(v[k]));
            e2[k] = s256_t'($signed(v[6 + k])) - s256_t'($signed(v[k]));
        end
        for (int k = 0; k < 3; k++) begin
            p = p + u256_t'(e1[k] * e1[k]);
            q = q + e1[k] * e2[k];
            cr = e1[(k + 1) % 3] * e2[(k + 2) % 3] - e1[(k + 2) % 3] * e2[(k + 1) % 3];
            c2 = c2 + u256_t'(cr * cr);
        end
        r = '0;
        if (p == 0 || c2 == 0) begin
            r.deg = 1'b1;
            return r;
        end
        len = floor_root(p);
        area = floor_root(c2);
        den = len * area;
        inv = div_round(u256_t'(1) << (2 * FB), len);
        r.w[0] = clamp_weight(inv, inv != 0);
        r.w[1] = clamp_weight(inv, 1'b0);
        r.w[3] = scaled_weight(q - s256_t'(p), den);
        r.w[4] = scaled_weight(-q, den);
        r.w[5] = scaled_weight(s256_t'(p), den);
        return r;
    endfunction

    task automatic send_triangle(input logic [NV-1:0][CW-1:0] v, input bit typed,
                                 input t_weights wt);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = v;
        do @(posedge i_clk); while (!o_s_axis_tready);
        weights_due.push_back(typed ? wt : triangle_weights(v));
        n_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = {$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom};
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [CW-1:0] q16(input int x);
        return CW'(x) << FB;
    endfunction

    function automatic logic [CW-1:0] coord_rand(input int mode);
        case (mode)
            0: return $urandom;
            1: return CW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return CW'($signed($urandom_range(0, 64)) - 32);
            default: return q16($urandom_range(0, 200) - 100);
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 15);
                i_m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_weights got, want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_triangle_deformation_operator: done, errors");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.w   = o_m_axis_tdata;
            got.deg = o_m_axis_tuser[0];
            if (weights_due.size() == 0) begin
                $error("unexpected output word");
                n_errors++;
            end else begin
                want = weights_due.pop_front();
                n_checked++;
                if (want.deg) n_deg++;
                for (int j = 0; j < NW_OUT; j++)
                    if (got.w[j] !== want.w[j]) begin
                        $error("w%0d%0d expected %h got %h", j / 3, j % 3,
                               want.w[j], got.w[j]);
                        n_errors++;
                    end
                if (got.deg !== want.deg) begin
                    $error("degenerate expected %b got %b", want.deg, got.deg);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_row     rows[$];
        t_row     r;
        t_weights unit_w;
        logic [NV-1:0][CW-1:0] v;
        int       mode, kind, waited;

        cycles = 0;
        n_errors = 0;
        n_sent = 0;
        n_deg = 0;
        n_checked = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        unit_w = '0;
        unit_w.w[0] = -q16(1);
        unit_w.w[1] = q16(1);
        unit_w.w[3] = -q16(1);
        unit_w.w[5] = q16(1);
        r.typed = 1'b1;
        r.v = '0;
        r.wt = '0;
        r.wt.deg = 1'b1;
        rows.push_back(r);                               // all vertices at origin
        r.v = {q16(5), q16(5), q16(5), q16(1), q16(2), q16(3), q16(1), q16(2), q16(3)};
        rows.push_back(r);                               // zero edge e1
        r.v = {q16(6), q16(4), q16(2), q16(3), q16(2), q16(1), CW'(0), CW'(0), CW'(0)};
        rows.push_back(r);                               // collinear, zero area
        r.v = {CW'(0), CW'(0), CW'(0), CW'(0), CW'(0), q16(1), CW'(0), CW'(0), CW'(0)};
        r.v = '0;
        r.v[3] = q16(1);
        r.v[7] = q16(1);
        r.wt = unit_w;
        rows.push_back(r);                               // unit right triangle
        r.typed = 1'b0;
        r.v = {NV{32'h8000_0000}};
        rows.push_back(r);
        r.v = {{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h8000_0000}}};
        rows.push_back(r);
        r.v = {{3{32'h8000_0000}}, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}};
        rows.push_back(r);                               // largest edge
        r.v = {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, {3{32'h7fff_ffff}}};
        rows.push_back(r);
        r.v = '0;
        r.v[3] = 32'd1;
        r.v[7] = 32'd1;
        rows.push_back(r);                               // tiniest triangle, saturates
        r.v = '0;
        r.v[3] = 32'hffff_ffff;
        r.v[8] = 32'd1;
        rows.push_back(r);
        r.v = {q16(0), q16(3), q16(-2), q16(1), q16(-1), q16(4), q16(7), q16(0), q16(-5)};
        rows.push_back(r);
        r.v = {32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000,
               32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'h0, 32'h1};
        rows.push_back(r);
        foreach (rows[i]) send_triangle(rows[i].v, rows[i].typed, rows[i].wt);

        for (int i = 0; i < N_RAND; i++) begin
            if (i == N_RAND / 2) hold_req = 1'b1;
            if (i == N_RAND - TAIL_FREE) calm = 1'b1;
            mode = $urandom_range(0, 3);
            for (int k = 0; k < NV; k++) v[k] = coord_rand(mode);
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                for (int k = 0; k < 3; k++) v[3 + k] = v[k];      // repeated vertex
            end else if (kind == 1) begin
                for (int k = 0; k < 3; k++) v[6 + k] = v[k];      // zero e2
            end else if (kind == 2) begin
                for (int k = 0; k < 3; k++) begin                 // collinear
                    v[k] = coord_rand(3);
                    v[3 + k] = v[k] + coord_rand(2);
                    v[6 + k] = v[k] + 2 * (v[3 + k] - v[k]);
                end
            end
            send_triangle(v, 1'b0, '0);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        waited = 0;
        while (weights_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        $display("sent %0d triangles, checked %0d results, %0d degenerate",
                 n_sent, n_checked, n_deg);
        $display("covered extremes, tiny and degenerate triangles, stalls and a long hold-off");
        if (n_errors == 0 && weights_due.size() == 0)
            $display("tb_triangle_deformation_operator: done, clean");
        else
            $display("tb_triangle_deformation_operator: done, errors");
        $finish;
    end

endmodule
